// ===== hdl/sha256s_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha256s_pkg;

	localparam logic [5:0] LEN_OFFSET = 6'd56;
	localparam logic [5:0] FILL_LAST  = 6'd63;
	localparam logic [5:0] ROUND_LAST = 6'd63;
	localparam logic [1:0] PART_LAST  = 2'd3;
	localparam logic [7:0] PAD_MARKER = 8'h80;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INITIAL_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		BSEL_INPUT,
		BSEL_MARKER,
		BSEL_ZERO,
		BSEL_LENGTH
	} byte_sel_t;

	typedef struct packed {
		logic      shift_byte;
		byte_sel_t byte_sel;
		logic      load_vars;
		logic      run_round;
		logic      add_hash;
		logic      count_block;
		logic      cap_len;
		logic      init_hash;
		logic [5:0] round;
		logic [5:0] fill;
		logic [1:0] part;
	} cmd_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		logic [63:0] dbl;
		dbl = {x, x} >> n;
		return dbl[31:0];
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

// ===== hdl/sha256s_if.sv =====
// Valid/ready channel interfaces for the byte stream and the digest parts.
interface sha256s_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       end_of_message;

	modport source (output valid, output data_byte, output byte_valid,
		output end_of_message, input ready);
	modport sink (input valid, input data_byte, input byte_valid,
		input end_of_message, output ready);
endinterface

interface sha256s_digest_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_part;
	logic [1:0]  part_index;
	logic        last_part;

	modport source (output valid, output digest_part, output part_index,
		output last_part, input ready);
	modport sink (input valid, input digest_part, input part_index,
		input last_part, output ready);
endinterface

// ===== hdl/sha256s_ctrl.sv =====
// Controller state machine: byte fill, padding sequence, round count and digest output.
module sha256s_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_byte_valid,
	input  logic              in_eom,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        part_index,
	output logic              last_part,
	output sha256s_pkg::cmd_t cmd
);
	import sha256s_pkg::*;

	state_t     state_q, state_d;
	logic [5:0] fill_q, fill_d;
	logic [5:0] round_q, round_d;
	logic [1:0] part_q, part_d;
	logic       eom_q, eom_d;
	logic       pad_q, pad_d;
	logic       marker_q, marker_d;
	logic       spill_q, spill_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			round_q  <= '0;
			part_q   <= '0;
			eom_q    <= 1'b0;
			pad_q    <= 1'b0;
			marker_q <= 1'b0;
			spill_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			round_q  <= round_d;
			part_q   <= part_d;
			eom_q    <= eom_d;
			pad_q    <= pad_d;
			marker_q <= marker_d;
			spill_q  <= spill_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		round_d   = round_q;
		part_d    = part_q;
		eom_d     = eom_q;
		pad_d     = pad_q;
		marker_d  = marker_q;
		spill_d   = spill_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		cmd.round = round_q;
		cmd.fill  = fill_q;
		cmd.part  = part_q;

		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_byte_valid) begin
						cmd.shift_byte = 1'b1;
						cmd.byte_sel   = BSEL_INPUT;
						fill_d         = fill_q + 6'd1;
					end
					if (in_byte_valid && fill_q == FILL_LAST) begin
						// The byte completes a block; padding waits for its compression.
						eom_d   = in_eom;
						state_d = ST_LOAD;
					end else if (in_eom) begin
						pad_d    = 1'b1;
						marker_d = 1'b0;
						state_d  = ST_PAD;
					end
				end
			end
			ST_LOAD: begin
				cmd.load_vars = 1'b1;
				round_d       = '0;
				state_d       = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.run_round = 1'b1;
				round_d       = round_q + 6'd1;
				if (round_q == ROUND_LAST) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.add_hash = 1'b1;
				if (pad_q) begin
					if (spill_q) begin
						spill_d = 1'b0;
						state_d = ST_PAD;
					end else begin
						part_d  = '0;
						state_d = ST_OUT;
					end
				end else begin
					cmd.count_block = 1'b1;
					if (eom_q) begin
						eom_d    = 1'b0;
						pad_d    = 1'b1;
						marker_d = 1'b0;
						state_d  = ST_PAD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_PAD: begin
				cmd.shift_byte = 1'b1;
				fill_d         = fill_q + 6'd1;
				if (!marker_q) begin
					// The marker byte also latches the bit length of the message.
					cmd.byte_sel = BSEL_MARKER;
					cmd.cap_len  = 1'b1;
					marker_d     = 1'b1;
					spill_d      = (fill_q >= LEN_OFFSET);
				end else if (fill_q >= LEN_OFFSET && !spill_q) begin
					cmd.byte_sel = BSEL_LENGTH;
				end else begin
					cmd.byte_sel = BSEL_ZERO;
				end
				if (fill_q == FILL_LAST) begin
					state_d = ST_LOAD;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					part_d = part_q + 2'd1;
					if (part_q == PART_LAST) begin
						cmd.init_hash = 1'b1;
						pad_d         = 1'b0;
						state_d       = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign part_index = part_q;
	assign last_part  = (part_q == PART_LAST);

endmodule

// ===== hdl/sha256s_dp.sv =====
// Datapath: message schedule window, round variables, hash words and length register.
module sha256s_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  sha256s_pkg::cmd_t cmd,
	input  logic [7:0]        data_byte,
	output logic [63:0]       digest_part
);
	import sha256s_pkg::*;

	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic [57:0] count_q;
	logic [63:0] len_q;

	logic [7:0]  byte_in;
	logic [31:0] w_new;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] maj;

	always_comb begin
		case (cmd.byte_sel)
			BSEL_INPUT:  byte_in = data_byte;
			BSEL_MARKER: byte_in = PAD_MARKER;
			BSEL_LENGTH: byte_in = len_q[63:56];
			default:     byte_in = 8'h00;
		endcase
	end

	// The window holds words t..t+15, so word 0 is always the current round's word.
	assign w_new = w_q[0] + small_sigma0(w_q[1]) + w_q[9] + small_sigma1(w_q[14]);
	assign ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1    = v_q[7] + big_sigma1(v_q[4]) + ch + ROUND_K[cmd.round] + w_q[0];
	assign t2    = big_sigma0(v_q[0]) + maj;

	always_ff @(posedge clk) begin
		if (cmd.shift_byte) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= {w_q[i][23:0], w_q[i + 1][31:24]};
			end
			w_q[15] <= {w_q[15][23:0], byte_in};
		end else if (cmd.run_round) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_vars) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (cmd.run_round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_len) begin
			// Bit length wraps modulo 2^64, so the top bits of the count drop out.
			len_q <= {count_q[54:0], cmd.fill, 3'b000};
		end else if (cmd.shift_byte && cmd.byte_sel == BSEL_LENGTH) begin
			len_q <= {len_q[55:0], 8'h00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= INITIAL_HASH[i];
			end
			count_q <= '0;
		end else begin
			if (cmd.init_hash) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= INITIAL_HASH[i];
				end
				count_q <= '0;
			end else begin
				if (cmd.add_hash) begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
				end
				if (cmd.count_block) begin
					count_q <= count_q + 58'd1;
				end
			end
		end
	end

	assign digest_part = {h_q[{cmd.part, 1'b0}], h_q[{cmd.part, 1'b1}]};

endmodule

// ===== hdl/sha256_stream_hasher.sv =====
// A message byte is taken in ST_IDLE; a 64th byte starts a compression (ST_LOAD, ST_ROUND, ST_ADD).
// End of message: padding bytes are shifted in, with one or two compressions,
// then four digest transactions, one per cycle while the sink is ready.
// One transaction is in work at a time; input is not taken during compression or output.
// Reset: asynchronous, active low; hash words return to the initial values, counts clear.
module sha256_stream_hasher (
	input  logic             clk,
	input  logic             arst_n,
	sha256s_byte_if.sink     byte_stream,
	sha256s_digest_if.source digest_stream
);
	import sha256s_pkg::*;

	cmd_t cmd;

	sha256s_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (byte_stream.valid),
		.in_byte_valid (byte_stream.byte_valid),
		.in_eom        (byte_stream.end_of_message),
		.in_ready      (byte_stream.ready),
		.out_valid     (digest_stream.valid),
		.out_ready     (digest_stream.ready),
		.part_index    (digest_stream.part_index),
		.last_part     (digest_stream.last_part),
		.cmd           (cmd)
	);

	sha256s_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (byte_stream.data_byte),
		.digest_part (digest_stream.digest_part)
	);

endmodule

// ===== hdl/sha256s_checker.sv =====
// Port-level checker for the SHA-256 stream hasher and its bind to the top level.
module sha256s_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] part_index,
	input logic       last_part
);

	// Input is never taken while a digest is being delivered.
	a_no_input_during_output: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while digest output is pending");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_part == (part_index == 2'd3)))
		else $error("last_part does not match part_index");

	a_part_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_part) |=>
			(out_valid && part_index == 2'($past(part_index) + 2'd1)))
		else $error("digest parts out of order");

	a_output_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_part) |=> (!out_valid && in_ready))
		else $error("output continues after the last part");

endmodule

bind sha256_stream_hasher sha256s_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (byte_stream.ready),
	.out_valid  (digest_stream.valid),
	.out_ready  (digest_stream.ready),
	.part_index (digest_stream.part_index),
	.last_part  (digest_stream.last_part)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the SHA-256 stream hasher, with its own digest predictor.
`timescale 1ns / 1ps

module tb;

	localparam int RESET_CYCLES = 7;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 300;
	localparam int PHASE_ITEMS  = 90;

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] SHA_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct packed {
		logic [63:0] part;
		logic [1:0]  index;
		logic        last;
	} digest_word_t;

	logic clk = 1'b0;
	logic arst_n;

	sha256s_byte_if   byte_if ();
	sha256s_digest_if digest_if ();

	sha256_stream_hasher DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_stream   (byte_if),
		.digest_stream (digest_if)
	);

	// Predictor state: chaining value, completed blocks and the partial block.
	logic [31:0] chain [8];
	logic [57:0] blocks_done;
	logic [7:0]  pending [64];
	int unsigned pending_fill;

	digest_word_t digest_words_due [$];

	int source_idle_pct;
	int sink_idle_pct;
	int mismatches;
	int items_counted;
	int bytes_hashed;
	int messages_hashed;
	int parts_checked;
	int stall_cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void compress_pending();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		for (int i = 0; i < 16; i++)
			w[i] = {pending[4*i], pending[4*i+1], pending[4*i+2], pending[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		{a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
			chain[4], chain[5], chain[6], chain[7]};
		for (int t = 0; t < 64; t++) begin
			t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
				+ SHA_K[t] + w[t];
			t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g;
			g = f;
			f = e;
			e = d + t1;
			d = c;
			c = b;
			b = a;
			a = t1 + t2;
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
		chain[4] += e;
		chain[5] += f;
		chain[6] += g;
		chain[7] += h;
	endfunction

	function automatic void restart_digest();
		for (int i = 0; i < 8; i++)
			chain[i] = SHA_IV[i];
		blocks_done = '0;
		pending_fill = 0;
	endfunction

	// Applies one accepted transaction and queues the four digest parts on end of message.
	function automatic void predict_item(input logic [7:0] data, input logic take,
		input logic finish);
		logic [63:0] bit_len;
		digest_word_t word;
		if (take) begin
			pending[pending_fill] = data;
			pending_fill++;
			bytes_hashed++;
			if (pending_fill == 64) begin
				compress_pending();
				blocks_done++;
				pending_fill = 0;
			end
		end
		if (!finish)
			return;
		// The length wraps modulo 2^64, so the top bits of the product are dropped.
		bit_len = {blocks_done[54:0], pending_fill[5:0], 3'b000};
		pending[pending_fill] = 8'h80;
		pending_fill++;
		if (pending_fill > 56) begin
			for (int i = pending_fill; i < 64; i++)
				pending[i] = 8'h00;
			compress_pending();
			pending_fill = 0;
		end
		for (int i = pending_fill; i < 56; i++)
			pending[i] = 8'h00;
		for (int i = 0; i < 8; i++)
			pending[56 + i] = bit_len[63 - 8*i -: 8];
		compress_pending();
		for (int i = 0; i < 4; i++) begin
			word.part = {chain[2*i], chain[2*i+1]};
			word.index = 2'(i);
			word.last = (2'(i) == sha256s_pkg::PART_LAST);
			digest_words_due.push_back(word);
		end
		messages_hashed++;
		restart_digest();
	endfunction

	function automatic void note_mismatch(input string what, input logic [63:0] want,
		input logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch in %s: expected %h, got %h", what, want, got);
	endfunction

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_item(input logic [7:0] data, input logic take, input logic finish);
		while ($urandom_range(99) < source_idle_pct) begin
			byte_if.valid <= 1'b0;
			byte_if.data_byte <= 8'($urandom_range(255));
			byte_if.byte_valid <= 1'($urandom_range(1));
			byte_if.end_of_message <= 1'($urandom_range(1));
			@(negedge clk);
		end
		byte_if.valid <= 1'b1;
		byte_if.data_byte <= data;
		byte_if.byte_valid <= take;
		byte_if.end_of_message <= finish;
		do
			@(posedge clk);
		while (!byte_if.ready);
		predict_item(data, take, finish);
		items_counted++;
		@(negedge clk);
	endtask

	task automatic test_empty_message();
		send_item(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	task automatic test_byte_with_end();
		send_item("a", 1'b1, 1'b0);
		send_item("b", 1'b1, 1'b0);
		send_item("c", 1'b1, 1'b1);
	endtask

	task automatic test_byte_extremes();
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hff, 1'b0, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
	endtask

	task automatic test_ignored_bytes();
		send_item(8'h5a, 1'b1, 1'b0);
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'ha5, 1'b1, 1'b0);
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'h3c, 1'b0, 1'b1);
		// Back-to-back ends: the second hashes the empty string again.
		send_item(8'h81, 1'b0, 1'b1);
	endtask

	task automatic send_random_message();
		int length;
		logic end_on_byte;
		// Mostly short messages; the rest sit on the padding and block edges.
		if ($urandom_range(99) < 70) begin
			length = $urandom_range(12);
		end else begin
			case ($urandom_range(3))
				0: length = 55;
				1: length = 56;
				2: length = 63;
				default: length = 64;
			endcase
		end
		end_on_byte = (length > 0) && ($urandom_range(1) == 1);
		for (int i = 0; i < length; i++) begin
			if ($urandom_range(99) < 10)
				send_item(8'($urandom_range(255)), 1'b0, 1'b0);
			send_item(8'($urandom_range(255)), 1'b1, end_on_byte && (i == length - 1));
		end
		if (!end_on_byte)
			send_item(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	task automatic test_random_messages(input int target);
		int start;
		start = items_counted;
		while (items_counted - start < target)
			send_random_message();
	endtask

	always @(negedge clk)
		digest_if.ready <= ($urandom_range(99) >= sink_idle_pct);

	always @(posedge clk) begin : check_digest
		digest_word_t want;
		if (arst_n) begin
			if (digest_if.valid && digest_if.ready) begin
				parts_checked++;
				if (digest_words_due.size() == 0) begin
					note_mismatch("unexpected digest part", '0, digest_if.digest_part);
				end else begin
					want = digest_words_due.pop_front();
					if (digest_if.digest_part !== want.part)
						note_mismatch("digest_part", want.part, digest_if.digest_part);
					if (digest_if.part_index !== want.index)
						note_mismatch("part_index", 64'(want.index),
							64'(digest_if.part_index));
					if (digest_if.last_part !== want.last)
						note_mismatch("last_part", 64'(want.last), 64'(digest_if.last_part));
				end
			end
			if ((byte_if.valid && byte_if.ready) || (digest_if.valid && digest_if.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		byte_if.valid = 1'b0;
		byte_if.data_byte = 8'h00;
		byte_if.byte_valid = 1'b0;
		byte_if.end_of_message = 1'b0;
		digest_if.ready = 1'b0;
		mismatches = 0;
		items_counted = 0;
		bytes_hashed = 0;
		messages_hashed = 0;
		parts_checked = 0;
		stall_cycles = 0;
		source_idle_pct = 21;
		sink_idle_pct = 82;
		restart_digest();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_message();
		test_byte_with_end();
		test_byte_extremes();
		test_ignored_bytes();
		test_random_messages(PHASE_ITEMS);

		source_idle_pct = 82;
		sink_idle_pct = 21;
		test_random_messages(PHASE_ITEMS);

		source_idle_pct = 0;
		sink_idle_pct = 0;
		test_random_messages(PHASE_ITEMS);

		byte_if.valid <= 1'b0;
		wait (digest_words_due.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d messages, %0d message bytes, %0d digest parts checked",
			messages_hashed, bytes_hashed, parts_checked);
		$display("idling phases: sender-light, receiver-light, none; %0d mismatches",
			mismatches);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
